// ===== rtl/qpps_pkg.sv =====
// Shared types and constants for the quadrature position servo.
// Used by the request interface and the top level; depends on nothing.
`timescale 1ns / 1ps

package qpps_pkg;

   // Command codes on the request channel
   typedef enum logic [2:0] {
      CMD_EDGE_A   = 3'd0,
      CMD_EDGE_B   = 3'd1,
      CMD_TICK     = 3'd2,
      CMD_TARGET   = 3'd3,
      CMD_TIMEOUT  = 3'd4,
      CMD_STOP     = 3'd5
   } cmd_type;

   // Fixed field widths
   localparam int CMD_BITS    = 3;
   localparam int TARGET_BITS = 24;
   localparam int GAIN_BITS   = 16;
   localparam int ACC_BITS    = 40;

   // Register file
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PROP_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INTEG_GAIN = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DERIV_GAIN = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOLERANCE  = 2'd3;
   localparam logic [CSR_DATA_BITS-1:0]  TOLERANCE_RESET = 16'd5;

   // Per-item control flags carried down the pipeline
   typedef struct packed {
      logic tick_run;   // tick that runs the control law
      logic stop_zero;  // stop that forces zero drive
      logic fired;      // target reached pulse
   } ctl_type;

endpackage

// ===== rtl/qpps_req_if.sv =====
// Request channel: valid/ready handshake with command, level and target.
// Depends on qpps_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface qpps_req_if;
   logic                               valid;
   logic                               ready;
   logic [qpps_pkg::CMD_BITS-1:0]      cmd;
   logic                               level;
   logic signed [qpps_pkg::TARGET_BITS-1:0] target_value;

   modport source (output valid, output cmd, output level, output target_value,
                   input ready);
   modport sink   (input valid, input cmd, input level, input target_value,
                   output ready);
endinterface

// ===== rtl/qpps_rsp_if.sv =====
// Response channel: valid/ready handshake with position and drive duty.
// Widths follow the servo's position and duty parameters.
`timescale 1ns / 1ps

interface qpps_rsp_if #(
   parameter int POS_BITS  = 24,
   parameter int DUTY_BITS = 7
);
   logic                       valid;
   logic                       ready;
   logic signed [POS_BITS-1:0] position;
   logic [DUTY_BITS-1:0]       drive_forward;
   logic [DUTY_BITS-1:0]       drive_reverse;
   logic                       target_reached;

   modport source (output valid, output position, output drive_forward,
                   output drive_reverse, output target_reached, input ready);
   modport sink   (input valid, input position, input drive_forward,
                   input drive_reverse, input target_reached, output ready);
endinterface

// ===== rtl/quadrature_pid_position_servo.sv =====
// Quadrature encoder position counter with a fixed-point PID drive.
// Depends on qpps_pkg, qpps_req_if and qpps_rsp_if.
`timescale 1ns / 1ps
//
//   channel   direction   handshake            payload
//   req_ch    in          valid/ready          cmd, level, target_value
//   rsp_ch    out         valid/ready          position, drive_forward,
//                                              drive_reverse, target_reached
//   csr_*     in          write enable only    index, 16-bit data
//
// One request per cycle sustained while the response channel is ready; each
// gives one response via input register, state update, three gain multiplies,
// sum and clamp; the state update (count, goal, accumulator) sets the rate.
// Active-high sync reset clears valids, state and gains; tolerance resets to 5.
// Every stage holds only while its successor is full, so bubbles close up and
// a waiting response does not stop new transfers until the pipe is full.

module quadrature_pid_position_servo #(
   parameter int POSITION_BITS  = 24,
   parameter int DUTY_MAX       = 100,
   parameter int GAIN_FRAC_BITS = 8,
   localparam int DUTY_W = $clog2(DUTY_MAX + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   qpps_req_if.sink                            req_ch,
   qpps_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_en,
   input  logic [qpps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [qpps_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int PB     = POSITION_BITS;
   localparam int GW     = qpps_pkg::GAIN_BITS;
   localparam int ACC_W  = qpps_pkg::ACC_BITS;
   localparam int ERR_W  = PB + 1;
   localparam int DIFF_W = PB + 2;
   localparam int P_W    = GW + 1 + ERR_W;
   localparam int I_W    = GW + 1 + ACC_W;
   localparam int D_W    = GW + 1 + DIFF_W;
   localparam int SUM_W  = ((I_W > D_W) ? I_W : D_W) + 2;
   localparam int CMP_W  = (ERR_W > GW) ? ERR_W : GW;

   localparam logic signed [SUM_W-1:0] ROUND_S = SUM_W'((1 << GAIN_FRAC_BITS) - 1);
   localparam logic signed [SUM_W-1:0] DMAX_S  = SUM_W'(DUTY_MAX);
   localparam logic signed [SUM_W-1:0] DMIN_S  = -DMAX_S;
   localparam logic [DUTY_W-1:0]       DUTY_TOP = DUTY_W'(DUTY_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MAX_S = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN_S = {1'b1, {(ACC_W-1){1'b0}}};

   // ---------------------------------------------------------------
   // Configuration registers
   logic [GW-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff, tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         tolerance_ff  <= qpps_pkg::TOLERANCE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            qpps_pkg::REG_PROP_GAIN:  prop_gain_ff  <= csr_write_data;
            qpps_pkg::REG_INTEG_GAIN: integ_gain_ff <= csr_write_data;
            qpps_pkg::REG_DERIV_GAIN: deriv_gain_ff <= csr_write_data;
            qpps_pkg::REG_TOLERANCE:  tolerance_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline occupancy and flow control
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic ready0, ready1, ready2, ready3;
   logic move01, move12, move23;

   assign ready3 = !v3_ff || rsp_ch.ready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign ready0 = !v0_ff || ready1;
   assign move01 = v0_ff && ready1;
   assign move12 = v1_ff && ready2;
   assign move23 = v2_ff && ready3;
   assign req_ch.ready = ready0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready0) v0_ff <= req_ch.valid;
         if (ready1) v1_ff <= v0_ff;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Input register
   logic [qpps_pkg::CMD_BITS-1:0]           cmd_ff;
   logic                                    level_ff;
   logic signed [qpps_pkg::TARGET_BITS-1:0] target_ff;

   always_ff @(posedge clock) begin
      if (ready0) begin
         cmd_ff    <= req_ch.cmd;
         level_ff  <= req_ch.level;
         target_ff <= req_ch.target_value;
      end
   end

   // ---------------------------------------------------------------
   // Architectural state
   logic [PB-1:0]           count_ff, count_in;
   logic [PB-1:0]           goal_ff, goal_in;
   logic                    level_a_ff, level_a_in, level_b_ff, level_b_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0] last_err_ff, last_err_in;
   logic                    goal_pending_ff, goal_pending_in;
   logic                    timeout_pending_ff, timeout_pending_in;
   logic                    halted_ff, halted_in;
   qpps_pkg::ctl_type       ctl_in;

   // Error path for a tick
   logic signed [ERR_W-1:0] err_raw, err_c;
   logic [ERR_W-1:0]        err_mag;
   logic                    within_tol;
   logic signed [ACC_W:0]   acc_ext;
   logic signed [ACC_W-1:0] acc_sat;
   logic signed [DIFF_W-1:0] diff_c;
   logic                    sign_change;
   logic [31:0]             target_wide;

   assign err_raw = $signed({goal_ff[PB-1], goal_ff}) - $signed({count_ff[PB-1], count_ff});
   assign err_c   = timeout_pending_ff ? '0 : err_raw;
   assign err_mag = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
   assign within_tol = CMP_W'(err_mag) < CMP_W'(tolerance_ff);
   assign acc_ext = $signed({acc_ff[ACC_W-1], acc_ff}) + (ACC_W + 1)'(err_c);
   assign acc_sat = (acc_ext[ACC_W] != acc_ext[ACC_W-1])
                  ? (acc_ext[ACC_W] ? ACC_MIN_S : ACC_MAX_S)
                  : acc_ext[ACC_W-1:0];
   assign diff_c  = DIFF_W'(err_c) - DIFF_W'(last_err_ff);
   assign sign_change = (err_c[ERR_W-1] != last_err_ff[ERR_W-1])
                     || ((err_c == '0) != (last_err_ff == '0));
   assign target_wide = 32'(target_ff);

   // Next state for the item leaving the input register
   always_comb begin
      count_in           = count_ff;
      goal_in            = goal_ff;
      level_a_in         = level_a_ff;
      level_b_in         = level_b_ff;
      acc_in             = acc_ff;
      last_err_in        = last_err_ff;
      goal_pending_in    = goal_pending_ff;
      timeout_pending_in = timeout_pending_ff;
      halted_in          = halted_ff;
      ctl_in             = '0;
      case (qpps_pkg::cmd_type'(cmd_ff))
         qpps_pkg::CMD_EDGE_A: begin
            count_in   = (level_a_ff == !level_b_ff) ? count_ff + 1'b1 : count_ff - 1'b1;
            level_a_in = level_ff;
         end
         qpps_pkg::CMD_EDGE_B: begin
            count_in   = (level_a_ff == level_b_ff) ? count_ff + 1'b1 : count_ff - 1'b1;
            level_b_in = level_ff;
         end
         qpps_pkg::CMD_TICK: begin
            if (!halted_ff) begin
               ctl_in.tick_run    = 1'b1;
               timeout_pending_in = 1'b0;
               if (timeout_pending_ff) goal_in = count_ff;
               if (goal_pending_ff && within_tol) begin
                  ctl_in.fired    = 1'b1;
                  goal_pending_in = 1'b0;
               end
               acc_in      = sign_change ? '0 : acc_sat;
               last_err_in = err_c;
            end
         end
         qpps_pkg::CMD_TARGET: begin
            goal_in         = target_wide[PB-1:0];
            goal_pending_in = 1'b1;
         end
         qpps_pkg::CMD_TIMEOUT: begin
            timeout_pending_in = 1'b1;
         end
         qpps_pkg::CMD_STOP: begin
            if (level_ff) begin
               halted_in        = 1'b1;
               ctl_in.stop_zero = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff           <= '0;
         goal_ff            <= '0;
         level_a_ff         <= 1'b0;
         level_b_ff         <= 1'b0;
         acc_ff             <= '0;
         last_err_ff        <= '0;
         goal_pending_ff    <= 1'b0;
         timeout_pending_ff <= 1'b0;
         halted_ff          <= 1'b0;
      end else if (move01) begin
         count_ff           <= count_in;
         goal_ff            <= goal_in;
         level_a_ff         <= level_a_in;
         level_b_ff         <= level_b_in;
         acc_ff             <= acc_in;
         last_err_ff        <= last_err_in;
         goal_pending_ff    <= goal_pending_in;
         timeout_pending_ff <= timeout_pending_in;
         halted_ff          <= halted_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: operands for the control law
   qpps_pkg::ctl_type        ctl1_ff;
   logic [PB-1:0]            pos1_ff;
   logic signed [ERR_W-1:0]  err1_ff;
   logic signed [ACC_W-1:0]  acc1_ff;
   logic signed [DIFF_W-1:0] diff1_ff;

   always_ff @(posedge clock) begin
      if (ready1) begin
         ctl1_ff  <= ctl_in;
         pos1_ff  <= count_in;
         err1_ff  <= err_c;
         acc1_ff  <= acc_sat;
         diff1_ff <= diff_c;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: gain products
   logic signed [P_W-1:0] prod_p_c, prod_p_ff;
   logic signed [I_W-1:0] prod_i_c, prod_i_ff;
   logic signed [D_W-1:0] prod_d_c, prod_d_ff;
   qpps_pkg::ctl_type     ctl2_ff;
   logic [PB-1:0]         pos2_ff;

   assign prod_p_c = $signed({1'b0, prop_gain_ff})  * err1_ff;
   assign prod_i_c = $signed({1'b0, integ_gain_ff}) * acc1_ff;
   assign prod_d_c = $signed({1'b0, deriv_gain_ff}) * diff1_ff;

   always_ff @(posedge clock) begin
      if (ready2) begin
         prod_p_ff <= prod_p_c;
         prod_i_ff <= prod_i_c;
         prod_d_ff <= prod_d_c;
         ctl2_ff   <= ctl1_ff;
         pos2_ff   <= pos1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: sum, scale toward zero, clamp and split into duty
   logic signed [SUM_W-1:0] sum_c, sum_adj, quot, quot_neg;
   logic [DUTY_W-1:0]       fwd_c, rev_c;

   assign sum_c    = SUM_W'(prod_p_ff) + SUM_W'(prod_i_ff) + SUM_W'(prod_d_ff);
   assign sum_adj  = sum_c + (sum_c[SUM_W-1] ? ROUND_S : '0);
   assign quot     = sum_adj >>> GAIN_FRAC_BITS;
   assign quot_neg = -quot;

   always_comb begin
      fwd_c = '0;
      rev_c = '0;
      if (quot > DMAX_S)        fwd_c = DUTY_TOP;
      else if (!quot[SUM_W-1])  fwd_c = quot[DUTY_W-1:0];
      else if (quot < DMIN_S)   rev_c = DUTY_TOP;
      else                      rev_c = quot_neg[DUTY_W-1:0];
   end

   // Response register; the duty fields double as the held drive state
   logic [PB-1:0]     pos3_ff;
   logic [DUTY_W-1:0] duty_fwd_ff, duty_rev_ff;
   logic              reached_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_fwd_ff <= '0;
         duty_rev_ff <= '0;
      end else if (move23) begin
         if (ctl2_ff.tick_run) begin
            duty_fwd_ff <= fwd_c;
            duty_rev_ff <= rev_c;
         end else if (ctl2_ff.stop_zero) begin
            duty_fwd_ff <= '0;
            duty_rev_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         pos3_ff    <= pos2_ff;
         reached_ff <= ctl2_ff.fired;
      end
   end

   assign rsp_ch.valid          = v3_ff;
   assign rsp_ch.position       = pos3_ff;
   assign rsp_ch.drive_forward  = duty_fwd_ff;
   assign rsp_ch.drive_reverse  = duty_rev_ff;
   assign rsp_ch.target_reached = reached_ff;

`ifndef SYNTHESIS
   // Stop is a latch that only reset releases
   assert property (@(posedge clock) disable iff (reset) halted_ff |=> halted_ff)
      else $error("halted flag released without reset");

   // Forward and reverse drive are never on together
   assert property (@(posedge clock) disable iff (reset)
      (duty_fwd_ff == '0) || (duty_rev_ff == '0))
      else $error("forward and reverse drive both nonzero");

   // Drive stays within the duty limit
   assert property (@(posedge clock) disable iff (reset)
      (duty_fwd_ff <= DUTY_TOP) && (duty_rev_ff <= DUTY_TOP))
      else $error("drive duty above limit");

   // A reached pulse consumes the pending target
   assert property (@(posedge clock) disable iff (reset)
      (move01 && ctl_in.fired) |=> !goal_pending_ff)
      else $error("target still pending after reached pulse");
`endif

endmodule
